// ===== hdl/gcr_pkg.sv =====
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared types, codes and reset values for the game-pad command responder.
// ----------------------------------------------------------------------------
package gcr_pkg;

    localparam int NUM_PORTS = 4;

    localparam logic [7:0] ID_DIGITAL  = 8'h41;
    localparam logic [7:0] ID_ANALOG   = 8'h73;
    localparam logic [7:0] ID_PRESSURE = 8'h79;
    localparam logic [7:0] ID_CONFIG   = 8'hF3;

    localparam logic [7:0] CMD_VREF      = 8'h40;
    localparam logic [7:0] CMD_MASK      = 8'h41;
    localparam logic [7:0] CMD_READ      = 8'h42;
    localparam logic [7:0] CMD_CONFIG    = 8'h43;
    localparam logic [7:0] CMD_SET_MODE  = 8'h44;
    localparam logic [7:0] CMD_MODEL     = 8'h45;
    localparam logic [7:0] CMD_ACT_INFO  = 8'h46;
    localparam logic [7:0] CMD_COMB_INFO = 8'h47;
    localparam logic [7:0] CMD_MODE_INFO = 8'h4C;
    localparam logic [7:0] CMD_ACT_ALIGN = 8'h4D;
    localparam logic [7:0] CMD_BTN_INFO  = 8'h4F;

    localparam logic [7:0] REPLY_TAIL     = 8'h5A;
    localparam logic [7:0] MODE_INFO_ZERO = 8'h04;
    localparam logic [7:0] MODE_INFO_ONE  = 8'h07;

    // reply bytes 3..8, byte 3 in bits 7:0
    localparam logic [47:0] REPLY_VREF      = 48'h5A_00_00_02_00_00;
    localparam logic [47:0] REPLY_MODEL     = 48'h00_01_02_00_02_03;
    localparam logic [47:0] REPLY_ACT_ZERO  = 48'h0A_00_02_01_00_00;
    localparam logic [47:0] REPLY_ACT_OTHER = 48'h14_01_01_01_00_00;
    localparam logic [47:0] REPLY_COMB      = 48'h00_01_00_02_00_00;
    localparam logic [47:0] REPLY_ALIGN     = 48'hFF_FF_FF_FF_FF_FF;

    localparam logic [3:0]  MOTOR_POS_RESET   = 4'd2;
    localparam logic [31:0] BUTTON_MASK_RESET = 32'h0003_FFFF;
    localparam logic [3:0]  VIB_ENABLE_RESET  = 4'd3;

    typedef struct packed {
        logic [1:0] port;
        logic [7:0] command;
        logic [7:0] byte_two;
        logic [7:0] param0;
        logic [7:0] param1;
        logic [7:0] param2;
        logic [7:0] param3;
        logic [7:0] param4;
        logic [7:0] param5;
        logic       pad_running;
        logic [7:0] driver_mode;
    } req_t;

    typedef struct packed {
        logic        responding;
        logic [7:0]  id_byte;
        logic [47:0] reply_data;
        logic        use_driver_data;
        logic        rumble_valid;
        logic [7:0]  rumble_left;
        logic [7:0]  rumble_right;
        logic        set_mode_valid;
        logic [7:0]  set_mode_value;
        logic [7:0]  set_lock_value;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  mode;
        logic        pressure;
        logic [7:0]  id;
        logic [7:0]  cfg;
        logic [7:0]  lock;
        logic [3:0]  left_pos;
        logic [3:0]  right_pos;
        logic [31:0] mask;
    } port_state_t;

    localparam port_state_t PORT_STATE_RESET = '{
        mode:      8'h00,
        pressure:  1'b0,
        id:        ID_DIGITAL,
        cfg:       8'h00,
        lock:      8'h00,
        left_pos:  MOTOR_POS_RESET,
        right_pos: MOTOR_POS_RESET,
        mask:      BUTTON_MASK_RESET
    };

    function automatic logic [7:0] frame_at(req_t r, logic [3:0] pos);
        logic [7:0] b;
        case (pos)
            4'd1:    b = r.command;
            4'd2:    b = r.byte_two;
            4'd3:    b = r.param0;
            4'd4:    b = r.param1;
            4'd5:    b = r.param2;
            4'd6:    b = r.param3;
            4'd7:    b = r.param4;
            4'd8:    b = r.param5;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/gcr_decode.sv =====
// ----------------------------------------------------------------------------
// gcr_decode
// Decodes one command frame against the addressed port's state and forms the
// reply, rumble and mode-set outputs and the port's next state.
// ----------------------------------------------------------------------------
module gcr_decode (
    input  gcr_pkg::req_t        req,
    input  gcr_pkg::port_state_t cur,
    input  logic                 port_ok,
    input  logic                 vib_en,
    output gcr_pkg::rsp_t        rsp,
    output gcr_pkg::port_state_t nxt
);
    import gcr_pkg::*;

    logic        do_read;
    logic [47:0] rep;
    logic [7:0]  prm [6];

    assign prm[0] = req.param0;
    assign prm[1] = req.param1;
    assign prm[2] = req.param2;
    assign prm[3] = req.param3;
    assign prm[4] = req.param4;
    assign prm[5] = req.param5;

    always_comb
    begin
        nxt     = cur;
        rsp     = '0;
        do_read = 1'b0;
        rep     = '0;
        if (port_ok)
        begin
            if (!req.pad_running)
            begin
                nxt.left_pos  = MOTOR_POS_RESET;
                nxt.right_pos = MOTOR_POS_RESET;
            end
            else
            begin
                rsp.responding = 1'b1;
                rsp.id_byte    = ID_CONFIG;
                unique case (req.command)
                    CMD_VREF:
                        rep = REPLY_VREF;
                    CMD_MASK:
                        if (cur.id != ID_DIGITAL)
                            rep = {REPLY_TAIL, 8'h00, cur.mask};
                    CMD_CONFIG:
                    begin
                        nxt.cfg = req.param0;
                        do_read = (cur.cfg == 8'h00);
                    end
                    CMD_READ:
                    begin
                        if (vib_en)
                        begin
                            rsp.rumble_valid = 1'b1;
                            rsp.rumble_left  = frame_at(req, cur.left_pos);
                            rsp.rumble_right = frame_at(req, cur.right_pos);
                        end
                        do_read = 1'b1;
                    end
                    CMD_SET_MODE:
                    begin
                        nxt.mode = req.param0;
                        nxt.lock = req.param1;
                        if (req.param0 != 8'h00)
                            nxt.id = cur.pressure ? ID_PRESSURE : ID_ANALOG;
                        else
                            nxt.id = ID_DIGITAL;
                        rsp.set_mode_valid = 1'b1;
                        rsp.set_mode_value = req.param0;
                        rsp.set_lock_value = req.param1;
                    end
                    CMD_MODEL:
                    begin
                        rep        = REPLY_MODEL;
                        rep[23:16] = cur.mode;
                    end
                    CMD_ACT_INFO:
                        rep = (req.param0 == 8'h00) ? REPLY_ACT_ZERO : REPLY_ACT_OTHER;
                    CMD_COMB_INFO:
                        rep = REPLY_COMB;
                    CMD_MODE_INFO:
                        rep[31:24] = (req.param0 == 8'h00) ? MODE_INFO_ZERO : MODE_INFO_ONE;
                    CMD_ACT_ALIGN:
                    begin
                        rep = REPLY_ALIGN;
                        for (int k = 0; k < 6; k++)
                        begin
                            if (prm[k] == 8'h00)
                                nxt.right_pos = 4'(k + 3);
                            if (prm[k] == 8'h01)
                                nxt.left_pos = 4'(k + 3);
                        end
                    end
                    CMD_BTN_INFO:
                    begin
                        nxt.id       = ID_PRESSURE;
                        nxt.pressure = 1'b1;
                        nxt.mask     = {req.param3, req.param2, req.param1, req.param0};
                        rep[47:40]   = REPLY_TAIL;
                    end
                    default:
                        rep = '0;
                endcase

                if (do_read)
                begin
                    if (nxt.lock == 8'h00 && nxt.mode != req.driver_mode)
                    begin
                        nxt.mode = req.driver_mode;
                        nxt.id   = (req.driver_mode != 8'h00) ? ID_ANALOG : ID_DIGITAL;
                    end
                    rsp.id_byte         = nxt.id;
                    rsp.use_driver_data = 1'b1;
                end
                else
                begin
                    rsp.reply_data = rep;
                end
            end
        end
    end

endmodule

// ===== hdl/gamepad_command_responder_core.sv =====
// ----------------------------------------------------------------------------
// gamepad_command_responder_core
// Emulated game-pad command responder: per-port state, one reply per frame.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  cmd     | in        | cmd_valid / cmd_stall | port, command, byte_two,
//          |           |                       | param0..param5, pad_running,
//          |           |                       | driver_mode
//  rsp     | out       | rsp_valid / rsp_stall | responding .. set_lock_value
//  cfg     | in        | cfg_valid / cfg_ready | cfg_data (vibration enable)
//
// One request per cycle while no held result stalls cmd; the result passes
// through the input register and the result register around the decoder.
// Per-port state is updated as a request leaves the input register, so the
// next request on the same port sees it. Reset restores all ports at once.
// A held result stalls the input register, which then stalls cmd.
// ----------------------------------------------------------------------------
module gamepad_command_responder_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  port,
    input  logic [7:0]  command,
    input  logic [7:0]  byte_two,
    input  logic [7:0]  param0,
    input  logic [7:0]  param1,
    input  logic [7:0]  param2,
    input  logic [7:0]  param3,
    input  logic [7:0]  param4,
    input  logic [7:0]  param5,
    input  logic        pad_running,
    input  logic [7:0]  driver_mode,

    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        responding,
    output logic [7:0]  id_byte,
    output logic [47:0] reply_data,
    output logic        use_driver_data,
    output logic        rumble_valid,
    output logic [7:0]  rumble_left,
    output logic [7:0]  rumble_right,
    output logic        set_mode_valid,
    output logic [7:0]  set_mode_value,
    output logic [7:0]  set_lock_value,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);
    import gcr_pkg::*;

    logic        in_valid_reg;
    req_t        in_req_reg;
    logic        out_valid_reg;
    rsp_t        out_rsp_reg;
    logic [3:0]  vib_enable_reg;
    port_state_t state_reg [NUM_PORTS];

    logic        advance;
    logic        fire;
    logic        accept;
    logic        port_hit;
    port_state_t cur_state;
    port_state_t next_state;
    rsp_t        result;
    req_t        req_in;

    assign req_in = '{
        port:        port,
        command:     command,
        byte_two:    byte_two,
        param0:      param0,
        param1:      param1,
        param2:      param2,
        param3:      param3,
        param4:      param4,
        param5:      param5,
        pad_running: pad_running,
        driver_mode: driver_mode
    };

    assign advance   = !out_valid_reg || !rsp_stall;
    assign fire      = in_valid_reg && advance;
    assign cmd_stall = in_valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cur_state = PORT_STATE_RESET;
        port_hit  = 1'b0;
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            if (int'(in_req_reg.port) == p)
            begin
                cur_state = state_reg[p];
                port_hit  = 1'b1;
            end
        end
    end

    gcr_decode u_decode (
        .req     (in_req_reg),
        .cur     (cur_state),
        .port_ok (port_hit),
        .vib_en  (vib_enable_reg[in_req_reg.port]),
        .rsp     (result),
        .nxt     (next_state)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            vib_enable_reg <= VIB_ENABLE_RESET;
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                state_reg[p] <= PORT_STATE_RESET;
            end
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= in_valid_reg;

            if (cfg_valid && cfg_ready)
                vib_enable_reg <= cfg_data;

            for (int p = 0; p < NUM_PORTS; p++)
            begin
                if (fire && int'(in_req_reg.port) == p)
                    state_reg[p] <= next_state;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_req_reg <= req_in;
        if (fire)
            out_rsp_reg <= result;
    end

    assign rsp_valid       = out_valid_reg;
    assign responding      = out_rsp_reg.responding;
    assign id_byte         = out_rsp_reg.id_byte;
    assign reply_data      = out_rsp_reg.reply_data;
    assign use_driver_data = out_rsp_reg.use_driver_data;
    assign rumble_valid    = out_rsp_reg.rumble_valid;
    assign rumble_left     = out_rsp_reg.rumble_left;
    assign rumble_right    = out_rsp_reg.rumble_right;
    assign set_mode_valid  = out_rsp_reg.set_mode_valid;
    assign set_mode_value  = out_rsp_reg.set_mode_value;
    assign set_lock_value  = out_rsp_reg.set_lock_value;

    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> rsp_valid && rsp_stall)
        else $error("cmd stalled without a held result");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_req_reg))
        else $error("input register changed while held");

    a_rumble_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rumble_valid |-> use_driver_data && responding && !set_mode_valid)
        else $error("rumble outside a read reply");

    a_driver_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && use_driver_data |-> reply_data == '0 && id_byte != ID_CONFIG)
        else $error("driver data reply carries reply bytes");

endmodule

// ===== tb/gcr_reply_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_reply_checker
// Watches the request, reply and vibration-enable channels of the command
// responder. Keeps its own per-port pad state, works out the reply for every
// accepted request, and compares each accepted reply field by field with the
// oldest outstanding one.
// ----------------------------------------------------------------------------
module gcr_reply_checker (
    input  logic          clk,
    input  logic          rst_n,

    input  logic          cmd_valid,
    input  logic          cmd_stall,
    input  gcr_pkg::req_t cmd_req,

    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  gcr_pkg::rsp_t rsp_seen,

    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [3:0]    cfg_data,

    output int            fail_count,
    output int            pending
);
    import gcr_pkg::*;

    localparam logic [47:0] VREF_BYTES      = 48'h5A_00_00_02_00_00;
    localparam logic [47:0] MODEL_BYTES     = 48'h00_01_02_00_02_03;
    localparam logic [47:0] ACT_ZERO_BYTES  = 48'h0A_00_02_01_00_00;
    localparam logic [47:0] ACT_OTHER_BYTES = 48'h14_01_01_01_00_00;
    localparam logic [47:0] COMB_BYTES      = 48'h00_01_00_02_00_00;

    port_state_t pad_state [NUM_PORTS];
    logic [3:0]  vib_enable;
    rsp_t        expected_replies [$];
    rsp_t        want;
    int          errors;

    function automatic rsp_t predict_reply(req_t r);
        rsp_t        o;
        port_state_t s;
        logic [7:0]  fb [9];
        logic [47:0] rep;
        logic        reads;
        o = '0;
        if (int'(r.port) >= NUM_PORTS)
            return o;
        s = pad_state[r.port];
        fb[0] = 8'h00;
        fb[1] = r.command;
        fb[2] = r.byte_two;
        fb[3] = r.param0;
        fb[4] = r.param1;
        fb[5] = r.param2;
        fb[6] = r.param3;
        fb[7] = r.param4;
        fb[8] = r.param5;
        if (!r.pad_running)
        begin
            s.left_pos  = 4'd2;
            s.right_pos = 4'd2;
            pad_state[r.port] = s;
            return o;
        end
        o.responding = 1'b1;
        o.id_byte    = ID_CONFIG;
        rep          = '0;
        reads        = 1'b0;
        case (r.command)
            CMD_VREF:
                rep = VREF_BYTES;
            CMD_MASK:
                if (s.id != ID_DIGITAL)
                    rep = {REPLY_TAIL, 8'h00, s.mask};
            CMD_CONFIG:
            begin
                if (s.cfg == 8'h00)
                    reads = 1'b1;
                s.cfg = fb[3];
            end
            CMD_READ:
            begin
                if (vib_enable[r.port])
                begin
                    o.rumble_valid = 1'b1;
                    o.rumble_left  = (s.left_pos < 4'd9) ? fb[s.left_pos] : 8'h00;
                    o.rumble_right = (s.right_pos < 4'd9) ? fb[s.right_pos] : 8'h00;
                end
                reads = 1'b1;
            end
            CMD_SET_MODE:
            begin
                s.mode = fb[3];
                s.lock = fb[4];
                if (s.mode != 8'h00)
                    s.id = s.pressure ? ID_PRESSURE : ID_ANALOG;
                else
                    s.id = ID_DIGITAL;
                o.set_mode_valid = 1'b1;
                o.set_mode_value = s.mode;
                o.set_lock_value = s.lock;
            end
            CMD_MODEL:
            begin
                rep = MODEL_BYTES;
                rep[23:16] = s.mode;
            end
            CMD_ACT_INFO:
                rep = (fb[3] == 8'h00) ? ACT_ZERO_BYTES : ACT_OTHER_BYTES;
            CMD_COMB_INFO:
                rep = COMB_BYTES;
            CMD_MODE_INFO:
                rep[31:24] = (fb[3] == 8'h00) ? MODE_INFO_ZERO : MODE_INFO_ONE;
            CMD_ACT_ALIGN:
            begin
                rep = '1;
                for (int k = 0; k < 6; k++)
                begin
                    if (fb[3 + k] == 8'h00)
                        s.right_pos = 4'(k + 3);
                    if (fb[3 + k] == 8'h01)
                        s.left_pos = 4'(k + 3);
                end
            end
            CMD_BTN_INFO:
            begin
                s.id        = ID_PRESSURE;
                s.pressure  = 1'b1;
                rep[47:40]  = REPLY_TAIL;
                s.mask      = {fb[6], fb[5], fb[4], fb[3]};
            end
            default:
                ;
        endcase
        if (reads)
        begin
            if (s.lock == 8'h00 && s.mode != r.driver_mode)
            begin
                s.mode = r.driver_mode;
                s.id   = (r.driver_mode != 8'h00) ? ID_ANALOG : ID_DIGITAL;
            end
            o.id_byte         = s.id;
            o.use_driver_data = 1'b1;
        end
        else
        begin
            o.reply_data = rep;
        end
        pad_state[r.port] = s;
        return o;
    endfunction

    task automatic check_field(input string name, input logic [47:0] want_v,
                               input logic [47:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                pad_state[p].mode      = 8'h00;
                pad_state[p].pressure  = 1'b0;
                pad_state[p].id        = ID_DIGITAL;
                pad_state[p].cfg       = 8'h00;
                pad_state[p].lock      = 8'h00;
                pad_state[p].left_pos  = 4'd2;
                pad_state[p].right_pos = 4'd2;
                pad_state[p].mask      = 32'h0003_FFFF;
            end
            vib_enable = 4'h3;
            expected_replies.delete();
            errors     = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("reply accepted with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("responding", want.responding, rsp_seen.responding);
                    check_field("id_byte", want.id_byte, rsp_seen.id_byte);
                    check_field("reply_data", want.reply_data, rsp_seen.reply_data);
                    check_field("use_driver_data", want.use_driver_data,
                                rsp_seen.use_driver_data);
                    check_field("rumble_valid", want.rumble_valid, rsp_seen.rumble_valid);
                    check_field("rumble_left", want.rumble_left, rsp_seen.rumble_left);
                    check_field("rumble_right", want.rumble_right, rsp_seen.rumble_right);
                    check_field("set_mode_valid", want.set_mode_valid,
                                rsp_seen.set_mode_valid);
                    check_field("set_mode_value", want.set_mode_value,
                                rsp_seen.set_mode_value);
                    check_field("set_lock_value", want.set_lock_value,
                                rsp_seen.set_lock_value);
                end
            end
            if (cfg_valid && cfg_ready)
                vib_enable = cfg_data;
            if (cmd_valid && !cmd_stall)
                expected_replies.push_back(predict_reply(cmd_req));
            fail_count <= errors;
            pending    <= expected_replies.size();
        end
    end

endmodule

// ===== tb/tb_gamepad_command_responder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gamepad_command_responder_core
// Drives command frames into the responder: a short directed pass over every
// command and corner case, then random traffic under several vibration-enable
// settings, with random gaps and reply stalls and one long reply hold-off.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_gamepad_command_responder_core;
    import gcr_pkg::*;

    localparam int         WATCHDOG_LIMIT   = 2000;
    localparam int         HOLD_OFF_CYCLES  = 100;
    localparam int         PHASE_REQUESTS   = 450;
    localparam logic [7:0] CMD_UNKNOWN_LOW  = 8'h00;
    localparam logic [7:0] CMD_UNKNOWN_HIGH = 8'hFF;

    logic        clk;
    logic        rst_n;

    logic        cmd_valid;
    logic        cmd_stall;
    req_t        cmd_req;

    logic        rsp_valid;
    logic        rsp_stall;
    logic        responding;
    logic [7:0]  id_byte;
    logic [47:0] reply_data;
    logic        use_driver_data;
    logic        rumble_valid;
    logic [7:0]  rumble_left;
    logic [7:0]  rumble_right;
    logic        set_mode_valid;
    logic [7:0]  set_mode_value;
    logic [7:0]  set_lock_value;
    rsp_t        rsp_seen;

    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    int          fail_count;
    int          pending;
    int          idle_cycles;
    logic        hold_off_req;
    logic        hold_off_done;

    assign rsp_seen = {responding, id_byte, reply_data, use_driver_data, rumble_valid,
                       rumble_left, rumble_right, set_mode_valid, set_mode_value,
                       set_lock_value};

    gamepad_command_responder_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .port            (cmd_req.port),
        .command         (cmd_req.command),
        .byte_two        (cmd_req.byte_two),
        .param0          (cmd_req.param0),
        .param1          (cmd_req.param1),
        .param2          (cmd_req.param2),
        .param3          (cmd_req.param3),
        .param4          (cmd_req.param4),
        .param5          (cmd_req.param5),
        .pad_running     (cmd_req.pad_running),
        .driver_mode     (cmd_req.driver_mode),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .responding      (responding),
        .id_byte         (id_byte),
        .reply_data      (reply_data),
        .use_driver_data (use_driver_data),
        .rumble_valid    (rumble_valid),
        .rumble_left     (rumble_left),
        .rumble_right    (rumble_right),
        .set_mode_valid  (set_mode_valid),
        .set_mode_value  (set_mode_value),
        .set_lock_value  (set_lock_value),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    gcr_reply_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_req    (cmd_req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_seen   (rsp_seen),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic req_t make_req(logic [1:0] p, logic [7:0] cmd, logic [7:0] b2,
                                      logic [47:0] params, logic run, logic [7:0] drv);
        req_t r;
        r.port        = p;
        r.command     = cmd;
        r.byte_two    = b2;
        r.param0      = params[7:0];
        r.param1      = params[15:8];
        r.param2      = params[23:16];
        r.param3      = params[31:24];
        r.param4      = params[39:32];
        r.param5      = params[47:40];
        r.pad_running = run;
        r.driver_mode = drv;
        return r;
    endfunction

    function automatic logic [7:0] skewed_byte();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:       b = 8'h00;
            1:       b = 8'h01;
            2:       b = 8'hFF;
            default: b = 8'($urandom);
        endcase
        return b;
    endfunction

    function automatic logic [7:0] known_cmd(int sel);
        logic [7:0] c;
        case (sel)
            0:       c = CMD_VREF;
            1:       c = CMD_MASK;
            2:       c = CMD_READ;
            3:       c = CMD_CONFIG;
            4:       c = CMD_SET_MODE;
            5:       c = CMD_MODEL;
            6:       c = CMD_ACT_INFO;
            7:       c = CMD_COMB_INFO;
            8:       c = CMD_MODE_INFO;
            9:       c = CMD_ACT_ALIGN;
            default: c = CMD_BTN_INFO;
        endcase
        return c;
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   sel;
        r.port        = 2'($urandom_range(0, 3));
        r.byte_two    = 8'($urandom);
        r.param0      = 8'($urandom);
        r.param1      = 8'($urandom);
        r.param2      = 8'($urandom);
        r.param3      = 8'($urandom);
        r.param4      = 8'($urandom);
        r.param5      = 8'($urandom);
        r.pad_running = ($urandom_range(0, 15) != 0);
        case ($urandom_range(0, 3))
            0:       r.driver_mode = 8'h00;
            1:       r.driver_mode = ID_ANALOG;
            default: r.driver_mode = 8'($urandom);
        endcase
        sel = $urandom_range(0, 19);
        if (sel < 2)
            r.command = 8'($urandom);
        else if (sel < 7)
            r.command = CMD_READ;
        else
            r.command = known_cmd($urandom_range(0, 10));
        case (r.command) inside
            CMD_ACT_ALIGN:
            begin
                r.param0 = skewed_byte();
                r.param1 = skewed_byte();
                r.param2 = skewed_byte();
                r.param3 = skewed_byte();
                r.param4 = skewed_byte();
                r.param5 = skewed_byte();
            end
            CMD_SET_MODE:
            begin
                r.param0 = skewed_byte();
                r.param1 = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00;
            end
            CMD_CONFIG, CMD_ACT_INFO, CMD_MODE_INFO:
                r.param0 = skewed_byte();
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(1, 3);
        else if (roll < 98)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 40);
        return gap;
    endfunction

    task automatic send_request(input req_t r, input logic allow_gap);
        int gap;
        cmd_valid <= 1'b1;
        cmd_req   <= r;
        do
            @(posedge clk);
        while (cmd_stall);
        gap = allow_gap ? pick_gap() : 0;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_vib_enable(input logic [3:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input logic with_hold_off);
        logic no_gaps;
        no_gaps = 1'b0;
        if (with_hold_off)
            hold_off_req <= 1'b1;
        for (int n = 0; n < PHASE_REQUESTS; n++)
        begin
            if (n % 60 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            send_request(random_request(), !no_gaps);
        end
        cmd_valid <= 1'b0;
    endtask

    // reply-side stall pattern, with one long hold-off once requested
    initial
    begin
        int roll;
        int len;
        rsp_stall     = 1'b0;
        hold_off_done = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                roll = $urandom_range(0, 9);
                if (roll < 4)
                begin
                    rsp_stall <= 1'b0;
                    len = $urandom_range(1, 20);
                end
                else if (roll == 4)
                begin
                    rsp_stall <= 1'b0;
                    len = $urandom_range(50, 150);
                end
                else if (roll < 9)
                begin
                    rsp_stall <= 1'b1;
                    len = $urandom_range(1, 3);
                end
                else
                begin
                    rsp_stall <= 1'b1;
                    len = $urandom_range(10, 40);
                end
                repeat (len) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        cmd_req      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = 4'h0;
        hold_off_req = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass under the reset vibration-enable setting
        send_request(make_req(2'd0, CMD_READ, 8'h00, 48'h0, 1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd0, CMD_MASK, 8'hFF, '1, 1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd0, CMD_READ, 8'hA5, 48'h0, 1'b1, ID_ANALOG), 1'b1);
        send_request(make_req(2'd0, CMD_MASK, 8'h00, 48'h0, 1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd1, CMD_VREF, 8'h00, 48'h0, 1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd1, CMD_MODEL, 8'h00, 48'h0, 1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd1, CMD_ACT_INFO, 8'h00, 48'h0, 1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd1, CMD_ACT_INFO, 8'h00, 48'h01, 1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd2, CMD_COMB_INFO, 8'h00, 48'h0, 1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd2, CMD_MODE_INFO, 8'h00, 48'h0, 1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd2, CMD_MODE_INFO, 8'h00, 48'hFF, 1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd0, CMD_ACT_ALIGN, 8'h00, 48'hFF_00_FF_FF_01_FF,
                              1'b1, ID_ANALOG), 1'b1);
        send_request(make_req(2'd0, CMD_READ, 8'h22, 48'h88_77_66_55_44_33,
                              1'b1, ID_ANALOG), 1'b1);
        send_request(make_req(2'd0, CMD_ACT_ALIGN, 8'h00, 48'h01_00_01_00_01_00,
                              1'b1, ID_ANALOG), 1'b1);
        send_request(make_req(2'd0, CMD_READ, 8'hFF, '1, 1'b1, 8'hFF), 1'b1);
        send_request(make_req(2'd3, CMD_CONFIG, 8'h00, 48'h01, 1'b1, ID_ANALOG), 1'b1);
        send_request(make_req(2'd3, CMD_CONFIG, 8'h00, 48'h00, 1'b1, ID_ANALOG), 1'b1);
        send_request(make_req(2'd3, CMD_CONFIG, 8'h00, 48'h00, 1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd1, CMD_SET_MODE, 8'h00, 48'h03_01, 1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd1, CMD_READ, 8'h17, 48'h0, 1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd1, CMD_BTN_INFO, 8'h00, 48'h00_00_12_34_56_78,
                              1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd1, CMD_MASK, 8'h00, 48'h0, 1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd1, CMD_SET_MODE, 8'h00, 48'h00_01, 1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd0, CMD_READ, 8'h33, '1, 1'b0, 8'hFF), 1'b1);
        send_request(make_req(2'd0, CMD_READ, 8'h5C, 48'h0, 1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd2, CMD_UNKNOWN_LOW, 8'hFF, '1, 1'b1, 8'h00), 1'b1);
        send_request(make_req(2'd2, CMD_UNKNOWN_HIGH, 8'h00, 48'h0, 1'b1, 8'h00), 1'b1);
        cmd_valid <= 1'b0;
        wait_drained();

        write_vib_enable(4'hF);
        run_random_phase(1'b1);
        wait_drained();

        write_vib_enable(4'h0);
        run_random_phase(1'b0);
        wait_drained();

        write_vib_enable(4'($urandom_range(1, 14)));
        run_random_phase(1'b0);
        wait_drained();

        write_vib_enable(4'($urandom));
        run_random_phase(1'b0);
        wait_drained();

        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
